/* src/ptpq_pkg.sv */
package ptpq_pkg;

	localparam int DEPTH      = 64;
	localparam int PRICE_BITS = 32;
	localparam int TIME_BITS  = 32;
	localparam int HANDLE_W   = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;

	// book side codes
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic                  action;
		logic [HANDLE_W-1:0]   order_handle;
		logic [PRICE_BITS-1:0] order_price;
		logic [TIME_BITS-1:0]  order_time;
	} req_t;

	typedef struct packed {
		logic                  front_valid;
		logic [HANDLE_W-1:0]   front_handle;
		logic [PRICE_BITS-1:0] front_price;
		logic [TIME_BITS-1:0]  front_time;
		logic [CNT_W-1:0]      entry_count;
		logic [1:0]            status;
	} rsp_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]   handle;
		logic [PRICE_BITS-1:0] price;
		logic [TIME_BITS-1:0]  stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

	// book state handed to the output side
	typedef struct packed {
		logic             done;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
		entry_t           front;
	} book_stat_t;

endpackage

/* src/ptpq_ram.sv */
module ptpq_ram #(
	parameter int WIDTH = 80,
	parameter int WORDS = 64,
	parameter int AW    = $clog2(WORDS)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [WORDS];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/ptpq_ctrl.sv */
module ptpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ptpq_pkg::req_t      req,
	input  logic                book_side,
	input  ptpq_pkg::entry_t    rd_data,
	output ptpq_pkg::mem_rd_t   mem_rd,
	output ptpq_pkg::mem_wr_t   mem_wr,
	output logic                busy,
	output ptpq_pkg::book_stat_t stat
);

	import ptpq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_TAIL = 2'd2;
	localparam logic [1:0] S_REM  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] i_q;
	logic             found_q;
	logic             done_q;
	logic [1:0]       status_q;
	entry_t           new_q;
	entry_t           carry_q;
	entry_t           front_q;

	logic             beats;
	logic             found_now;
	logic [CNT_W-1:0] i_next;
	logic             last;
	entry_t           place;

	// rank test of the new order against the entry just read
	always_comb begin
		if (new_q.price != rd_data.price) begin
			if (book_side == SIDE_SELL) begin
				beats = new_q.price < rd_data.price;
			end else begin
				beats = new_q.price > rd_data.price;
			end
		end else begin
			beats = new_q.stamp < rd_data.stamp;
		end
	end

	assign found_now = found_q | beats;
	assign i_next    = CNT_W'(i_q) + CNT_W'(1);
	assign last      = (i_next == count_q);
	assign place     = found_q ? carry_q : new_q;

	// memory port control
	always_comb begin
		mem_rd.en   = 1'b0;
		mem_rd.addr = '0;
		mem_wr.en   = 1'b0;
		mem_wr.addr = '0;
		mem_wr.data = place;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.action == ACT_INSERT) begin
						mem_rd.en = (count_q != CNT_W'(DEPTH)) && (count_q != '0);
					end else begin
						mem_rd.en   = (count_q > CNT_W'(1));
						mem_rd.addr = IDX_W'(1);
					end
				end
			end
			S_INS: begin
				mem_wr.en   = found_now;
				mem_wr.addr = i_q;
				mem_rd.en   = !last;
				mem_rd.addr = i_next[IDX_W-1:0];
			end
			S_TAIL: begin
				mem_wr.en   = 1'b1;
				mem_wr.addr = count_q[IDX_W-1:0];
			end
			S_REM: begin
				mem_wr.en   = 1'b1;
				mem_wr.addr = i_q - IDX_W'(1);
				mem_wr.data = rd_data;
				mem_rd.en   = !last;
				mem_rd.addr = i_next[IDX_W-1:0];
			end
			default: begin
				mem_rd.en = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			i_q      <= '0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						i_q      <= '0;
						found_q  <= 1'b0;
						status_q <= ST_DONE;
						if (req.action == ACT_INSERT) begin
							if (count_q == CNT_W'(DEPTH)) begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
							end else if (count_q == '0) begin
								state_q <= S_TAIL;
							end else begin
								state_q <= S_INS;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
							end else if (count_q == CNT_W'(1)) begin
								count_q <= '0;
								done_q  <= 1'b1;
							end else begin
								i_q     <= IDX_W'(1);
								state_q <= S_REM;
							end
						end
					end
				end
				S_INS: begin
					if (found_now) begin
						found_q <= 1'b1;
					end
					if (last) begin
						state_q <= S_TAIL;
					end else begin
						i_q <= i_next[IDX_W-1:0];
					end
				end
				S_TAIL: begin
					count_q <= count_q + CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_REM: begin
					if (last) begin
						count_q <= count_q - CNT_W'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_next[IDX_W-1:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload, carried entry and front copy
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			new_q.handle <= req.order_handle;
			new_q.price  <= req.order_price;
			new_q.stamp  <= req.order_time;
		end
		if (state_q == S_INS && found_now) begin
			carry_q <= rd_data;
		end
		if (mem_wr.en && mem_wr.addr == '0) begin
			front_q <= mem_wr.data;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign stat.done   = done_q;
	assign stat.status = status_q;
	assign stat.count  = count_q;
	assign stat.front  = front_q;

endmodule

/* src/price_time_priority_queue_top.sv */
// An insert walks the stored orders in S_INS, if there are any, and writes the last entry in S_TAIL;
// a remove shifts the entries forward in S_REM; a refused or single-entry request answers in the next cycle.
// Throughput: one request per result; busy stays high while the sorted memory is walked,
// at most one entry read and one written per cycle through the single-read, single-write RAM.
// Results come on done for one cycle; the receiver cannot stall them.
// Reset clears the count and side to buy; stored entries are not cleared, none is read.
module price_time_priority_queue_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ptpq_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output ptpq_pkg::rsp_t   rsp,
	input  logic             cfg_we,
	input  logic             cfg_wdata
);

	import ptpq_pkg::*;

	logic                 book_side_q;
	mem_rd_t              mem_rd;
	mem_wr_t              mem_wr;
	logic [ENTRY_W-1:0]   ram_rd_data;
	entry_t               rd_entry;
	book_stat_t           stat;

	// side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			book_side_q <= SIDE_BUY;
		end else if (cfg_we) begin
			book_side_q <= cfg_wdata;
		end
	end

	ptpq_ram #(
		.WIDTH (ENTRY_W),
		.WORDS (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr.en),
		.wr_addr (mem_wr.addr),
		.wr_data (mem_wr.data),
		.rd_en   (mem_rd.en),
		.rd_addr (mem_rd.addr),
		.rd_data (ram_rd_data)
	);

	assign rd_entry = ram_rd_data;

	ptpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.book_side (book_side_q),
		.rd_data   (rd_entry),
		.mem_rd    (mem_rd),
		.mem_wr    (mem_wr),
		.busy      (busy),
		.stat      (stat)
	);

	// result assembly, front fields read as zero on an empty queue
	always_comb begin
		rsp.front_valid  = (stat.count != '0);
		rsp.front_handle = rsp.front_valid ? stat.front.handle : '0;
		rsp.front_price  = rsp.front_valid ? stat.front.price : '0;
		rsp.front_time   = rsp.front_valid ? stat.front.stamp : '0;
		rsp.entry_count  = stat.count;
		rsp.status       = stat.status;
	end

	assign done = stat.done;

endmodule
